@@ src/c8de_pkg.sv @@
// Package with shared types and constants for the CHIP-8 decode and flow execute block.
`default_nettype none
package c8de_pkg;
	localparam int TypeW = 6;
	localparam int ErrW = 3;
	localparam int WordW = 16;

	localparam logic [TypeW-1:0] T_CLS = 6'd0;
	localparam logic [TypeW-1:0] T_RET = 6'd1;
	localparam logic [TypeW-1:0] T_SYS = 6'd2;
	localparam logic [TypeW-1:0] T_JMP = 6'd3;
	localparam logic [TypeW-1:0] T_CALL = 6'd4;
	localparam logic [TypeW-1:0] T_SEQ = 6'd5;
	localparam logic [TypeW-1:0] T_SNE = 6'd6;
	localparam logic [TypeW-1:0] T_SEQR = 6'd7;
	localparam logic [TypeW-1:0] T_LD = 6'd8;
	localparam logic [TypeW-1:0] T_ADD = 6'd9;
	localparam logic [TypeW-1:0] T_ALU0 = 6'd10;
	localparam logic [TypeW-1:0] T_SHL = 6'd18;
	localparam logic [TypeW-1:0] T_SNER = 6'd19;
	localparam logic [TypeW-1:0] T_LDI = 6'd20;
	localparam logic [TypeW-1:0] T_JPV = 6'd21;
	localparam logic [TypeW-1:0] T_RND = 6'd22;
	localparam logic [TypeW-1:0] T_DRW = 6'd23;
	localparam logic [TypeW-1:0] T_SKP = 6'd24;
	localparam logic [TypeW-1:0] T_SKNP = 6'd25;
	localparam logic [TypeW-1:0] T_F07 = 6'd26;
	localparam logic [TypeW-1:0] T_F0A = 6'd27;
	localparam logic [TypeW-1:0] T_F15 = 6'd28;
	localparam logic [TypeW-1:0] T_F18 = 6'd29;
	localparam logic [TypeW-1:0] T_F1E = 6'd30;
	localparam logic [TypeW-1:0] T_F29 = 6'd31;
	localparam logic [TypeW-1:0] T_F33 = 6'd32;
	localparam logic [TypeW-1:0] T_F55 = 6'd33;
	localparam logic [TypeW-1:0] T_F65 = 6'd34;
	localparam logic [TypeW-1:0] T_INVALID = 6'd35;

	localparam logic [ErrW-1:0] E_NONE = 3'd0;
	localparam logic [ErrW-1:0] E_NOT_IMPL = 3'd1;
	localparam logic [ErrW-1:0] E_OVERFLOW = 3'd2;
	localparam logic [ErrW-1:0] E_UNDERFLOW = 3'd3;
	localparam logic [ErrW-1:0] E_BAD_ADDR = 3'd4;
	localparam logic [ErrW-1:0] E_INC_FAIL = 3'd5;

	typedef struct packed {
		logic [TypeW-1:0] itype;
		logic [3:0] x;
		logic [3:0] y;
		logic [7:0] nn;
		logic [11:0] nnn;
	} dec_t;

	function automatic logic [TypeW-1:0] classify(input logic [WordW-1:0] w);
		logic [TypeW-1:0] t;
		t = T_INVALID;
		case (w[15:12])
			4'h0: begin
				if (w[11:0] == 12'h0E0) t = T_CLS;
				else if (w[11:0] == 12'h0EE) t = T_RET;
				else t = T_SYS;
			end
			4'h1: t = T_JMP;
			4'h2: t = T_CALL;
			4'h3: t = T_SEQ;
			4'h4: t = T_SNE;
			4'h5: t = (w[3:0] == 4'h0) ? T_SEQR : T_INVALID;
			4'h6: t = T_LD;
			4'h7: t = T_ADD;
			4'h8: begin
				if (w[3] == 1'b0) t = T_ALU0 + {3'd0, w[2:0]};
				else if (w[3:0] == 4'hE) t = T_SHL;
				else t = T_INVALID;
			end
			4'h9: t = T_SNER;
			4'hA: t = T_LDI;
			4'hB: t = T_JPV;
			4'hC: t = T_RND;
			4'hD: t = T_DRW;
			4'hE: begin
				if (w[7:0] == 8'h9E) t = T_SKP;
				else if (w[7:0] == 8'hA1) t = T_SKNP;
				else t = T_INVALID;
			end
			default: begin
				case (w[7:0])
					8'h07: t = T_F07;
					8'h0A: t = T_F0A;
					8'h15: t = T_F15;
					8'h18: t = T_F18;
					8'h1E: t = T_F1E;
					8'h29: t = T_F29;
					8'h33: t = T_F33;
					8'h55: t = T_F55;
					8'h65: t = T_F65;
					default: t = T_INVALID;
				endcase
			end
		endcase
		return t;
	endfunction
endpackage
`default_nettype wire

@@ src/c8de_front.sv @@
// Front end: accepts instruction words, classifies them and feeds a two-entry queue.
`default_nettype none
module c8de_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [15:0] word,
	output logic q_valid,
	input wire logic q_ready,
	output c8de_pkg::dec_t q_data
);
	c8de_pkg::dec_t mem_q [2];
	logic wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic push, pop;
	c8de_pkg::dec_t d;

	always_comb begin
		d.itype = c8de_pkg::classify(word);
		d.x = word[11:8];
		d.y = word[7:4];
		d.nn = word[7:0];
		d.nnn = word[11:0];
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rptr_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

@@ src/c8de_back.sv @@
// Back end: executes the flow group against pc, return stack and V registers.
`default_nettype none
module c8de_back #(
	parameter int STACK_DEPTH = 16,
	parameter int ADDR_BITS = 12
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [11:0] mem_top,
	input wire logic q_valid,
	output logic q_ready,
	input wire c8de_pkg::dec_t q_data,
	output logic out_valid,
	input wire logic out_ready,
	output logic [5:0] instr_type,
	output logic success,
	output logic [2:0] error_code,
	output logic [11:0] pc_now,
	output logic [4:0] stack_level
);
	localparam int SpW = $clog2(STACK_DEPTH + 1);
	localparam int IdxW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic [ADDR_BITS-1:0] pc_q;
	logic [SpW-1:0] sp_q;
	logic [ADDR_BITS-1:0] stk_q [STACK_DEPTH];
	logic [7:0] v_q [16];

	logic [ADDR_BITS-1:0] pc_n;
	logic [SpW-1:0] sp_n;
	logic [2:0] err;
	logic push_en, v_en;
	logic [ADDR_BITS-1:0] base, inc1, inc2, popped;
	logic cond, ok1, ok2;
	logic fire;
	logic [IdxW-1:0] pop_idx, push_idx;
	logic [SpW-1:0] sp_dec;

	assign q_ready = !out_valid || out_ready;
	assign fire = q_valid && q_ready;
	assign sp_dec = sp_q - SpW'(1);
	assign pop_idx = sp_dec[IdxW-1:0];
	assign push_idx = sp_q[IdxW-1:0];
	assign popped = stk_q[pop_idx];

	always_comb begin
		pc_n = pc_q;
		sp_n = sp_q;
		err = c8de_pkg::E_NOT_IMPL;
		push_en = 1'b0;
		v_en = 1'b0;
		cond = 1'b0;
		base = pc_q;
		case (q_data.itype)
			c8de_pkg::T_SEQ: cond = (v_q[q_data.x] == q_data.nn);
			c8de_pkg::T_SNE: cond = (v_q[q_data.x] != q_data.nn);
			c8de_pkg::T_SEQR: cond = (v_q[q_data.x] == v_q[q_data.y]);
			c8de_pkg::T_RET: base = popped;
			default: cond = 1'b0;
		endcase
		inc1 = base + ADDR_BITS'(2);
		inc2 = base + ADDR_BITS'(4);
		ok1 = ({1'b0, base} + (ADDR_BITS+1)'(2)) <= (ADDR_BITS+1)'(mem_top);
		ok2 = ({1'b0, base} + (ADDR_BITS+1)'(4)) <= (ADDR_BITS+1)'(mem_top);
		case (q_data.itype)
			c8de_pkg::T_RET: begin
				if (sp_q == '0) err = c8de_pkg::E_UNDERFLOW;
				else begin
					sp_n = sp_dec;
					pc_n = ok1 ? inc1 : popped;
					err = ok1 ? c8de_pkg::E_NONE : c8de_pkg::E_INC_FAIL;
				end
			end
			c8de_pkg::T_JMP: begin
				if (q_data.nnn <= mem_top) begin
					pc_n = ADDR_BITS'(q_data.nnn);
					err = c8de_pkg::E_NONE;
				end else err = c8de_pkg::E_BAD_ADDR;
			end
			c8de_pkg::T_CALL: begin
				if (sp_q >= SpW'(STACK_DEPTH)) err = c8de_pkg::E_OVERFLOW;
				else begin
					push_en = 1'b1;
					sp_n = sp_q + SpW'(1);
					if (q_data.nnn <= mem_top) begin
						pc_n = ADDR_BITS'(q_data.nnn);
						err = c8de_pkg::E_NONE;
					end else err = c8de_pkg::E_BAD_ADDR;
				end
			end
			c8de_pkg::T_SEQ, c8de_pkg::T_SNE, c8de_pkg::T_SEQR: begin
				if (!ok1) err = c8de_pkg::E_INC_FAIL;
				else if (cond && !ok2) begin
					pc_n = inc1;
					err = c8de_pkg::E_INC_FAIL;
				end else begin
					pc_n = cond ? inc2 : inc1;
					err = c8de_pkg::E_NONE;
				end
			end
			c8de_pkg::T_LD: begin
				v_en = 1'b1;
				pc_n = ok1 ? inc1 : pc_q;
				err = ok1 ? c8de_pkg::E_NONE : c8de_pkg::E_INC_FAIL;
			end
			default: err = c8de_pkg::E_NOT_IMPL;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fire && push_en) stk_q[push_idx] <= pc_q;
		if (fire) begin
			instr_type <= q_data.itype;
			success <= (err == c8de_pkg::E_NONE);
			error_code <= err;
			pc_now <= pc_n[11:0];
			stack_level <= 5'(sp_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ADDR_BITS'(12'h200);
			sp_q <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < 16; i++) v_q[i] <= 8'd0;
		end else begin
			if (fire) begin
				pc_q <= pc_n;
				sp_q <= sp_n;
				if (v_en) v_q[q_data.x] <= q_data.nn;
				out_valid <= 1'b1;
			end else if (out_ready) out_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

@@ src/chip8_decode_and_flow_execute.sv @@
// Top level of the CHIP-8 instruction decoder with flow-group execution.
// One instruction word enters per transaction on the in channel (in_valid, in_ready, word).
// The front end classifies it and places it in a two-entry queue; the back end executes the
// flow group (return, jump, call, skips, load) and registers one result transaction on the
// out channel: instr_type, success, error_code, pc_now and stack_level.
// An input word passes a queue entry and then the output register before its result shows;
// throughput is one instruction per cycle unless out_ready stalls the output register.
// The cfg channel writes mem_top, the highest address pc may take; write it only when idle.
// Reset sets pc to 0x200, empties the return stack, clears the V registers and sets
// mem_top to 4095. When the receiver stalls, the output register holds its result, the
// queue fills, and in_ready falls once both queue entries are taken.
`default_nettype none
module chip8_decode_and_flow_execute #(
	parameter int STACK_DEPTH = 16,
	parameter int ADDR_BITS = 12
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [11:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [15:0] instruction_word,
	output logic out_valid,
	input wire logic out_ready,
	output logic [5:0] instr_type,
	output logic success,
	output logic [2:0] error_code,
	output logic [11:0] pc_now,
	output logic [4:0] stack_level
);
	logic [11:0] mem_top_q;
	logic q_valid, q_ready;
	c8de_pkg::dec_t q_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mem_top_q <= 12'hFFF;
		else if (cfg_valid) mem_top_q <= cfg_data;
	end

	c8de_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .word(instruction_word),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	c8de_back #(.STACK_DEPTH(STACK_DEPTH), .ADDR_BITS(ADDR_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .mem_top(mem_top_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.instr_type(instr_type), .success(success), .error_code(error_code),
		.pc_now(pc_now), .stack_level(stack_level)
	);
endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the CHIP-8 decode and flow-group execute block.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int LIMIT = 400000;

	typedef struct packed {
		logic [5:0] itype;
		logic ok;
		logic [2:0] err;
		logic [11:0] pc;
		logic [4:0] lvl;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [11:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] instruction_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [5:0] instr_type;
	logic success;
	logic [2:0] error_code;
	logic [11:0] pc_now;
	logic [4:0] stack_level;

	chip8_decode_and_flow_execute u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .instruction_word(instruction_word),
		.out_valid(out_valid), .out_ready(out_ready),
		.instr_type(instr_type), .success(success), .error_code(error_code),
		.pc_now(pc_now), .stack_level(stack_level)
	);

	logic [11:0] top_addr;
	logic [11:0] prog_ctr;
	logic [11:0] ret_stack [DEPTH];
	int sp;
	logic [7:0] vreg [16];

	outcome_t pending_q [$];
	int fails = 0;
	int cycles = 0;
	int sent = 0;
	int got = 0;
	int in_idle = 27;
	int out_idle = 75;

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic logic [5:0] opcode_class(input logic [15:0] w);
		logic [5:0] t;
		t = c8de_pkg::T_INVALID;
		unique case (w[15:12])
			4'h0: t = (w[11:0] == 12'h0E0) ? c8de_pkg::T_CLS :
				(w[11:0] == 12'h0EE) ? c8de_pkg::T_RET : c8de_pkg::T_SYS;
			4'h1: t = c8de_pkg::T_JMP;
			4'h2: t = c8de_pkg::T_CALL;
			4'h3: t = c8de_pkg::T_SEQ;
			4'h4: t = c8de_pkg::T_SNE;
			4'h5: if (w[3:0] == 4'h0) t = c8de_pkg::T_SEQR;
			4'h6: t = c8de_pkg::T_LD;
			4'h7: t = c8de_pkg::T_ADD;
			4'h8: begin
				if (w[3:0] <= 4'h7) t = 6'(c8de_pkg::T_ALU0 + w[3:0]);
				else if (w[3:0] == 4'hE) t = c8de_pkg::T_SHL;
			end
			4'h9: t = c8de_pkg::T_SNER;
			4'hA: t = c8de_pkg::T_LDI;
			4'hB: t = c8de_pkg::T_JPV;
			4'hC: t = c8de_pkg::T_RND;
			4'hD: t = c8de_pkg::T_DRW;
			4'hE: begin
				if (w[7:0] == 8'h9E) t = c8de_pkg::T_SKP;
				else if (w[7:0] == 8'hA1) t = c8de_pkg::T_SKNP;
			end
			default: begin
				case (w[7:0])
					8'h07: t = c8de_pkg::T_F07;
					8'h0A: t = c8de_pkg::T_F0A;
					8'h15: t = c8de_pkg::T_F15;
					8'h18: t = c8de_pkg::T_F18;
					8'h1E: t = c8de_pkg::T_F1E;
					8'h29: t = c8de_pkg::T_F29;
					8'h33: t = c8de_pkg::T_F33;
					8'h55: t = c8de_pkg::T_F55;
					8'h65: t = c8de_pkg::T_F65;
					default: t = c8de_pkg::T_INVALID;
				endcase
			end
		endcase
		return t;
	endfunction

	function automatic logic [2:0] step_pc();
		int nxt;
		nxt = prog_ctr + 2;
		if (nxt > top_addr) return c8de_pkg::E_INC_FAIL;
		prog_ctr = 12'(nxt);
		return c8de_pkg::E_NONE;
	endfunction

	function automatic logic [2:0] skip_pc(input logic cond);
		logic [2:0] e;
		e = c8de_pkg::E_NONE;
		if (cond) e = step_pc();
		if (e == c8de_pkg::E_NONE) e = step_pc();
		return e;
	endfunction

	function automatic outcome_t execute_word(input logic [15:0] w);
		outcome_t r;
		logic [2:0] e;
		logic [3:0] x;
		logic [3:0] y;
		x = w[11:8];
		y = w[7:4];
		r.itype = opcode_class(w);
		case (r.itype)
			c8de_pkg::T_RET: begin
				if (sp == 0) e = c8de_pkg::E_UNDERFLOW;
				else begin
					sp--;
					prog_ctr = ret_stack[sp];
					e = step_pc();
				end
			end
			c8de_pkg::T_JMP: begin
				if (w[11:0] > top_addr) e = c8de_pkg::E_BAD_ADDR;
				else begin
					prog_ctr = w[11:0];
					e = c8de_pkg::E_NONE;
				end
			end
			c8de_pkg::T_CALL: begin
				if (sp >= DEPTH) e = c8de_pkg::E_OVERFLOW;
				else begin
					ret_stack[sp] = prog_ctr;
					sp++;
					if (w[11:0] > top_addr) e = c8de_pkg::E_BAD_ADDR;
					else begin
						prog_ctr = w[11:0];
						e = c8de_pkg::E_NONE;
					end
				end
			end
			c8de_pkg::T_SEQ: e = skip_pc(vreg[x] == w[7:0]);
			c8de_pkg::T_SNE: e = skip_pc(vreg[x] != w[7:0]);
			c8de_pkg::T_SEQR: e = skip_pc(vreg[x] == vreg[y]);
			c8de_pkg::T_LD: begin
				vreg[x] = w[7:0];
				e = step_pc();
			end
			default: e = c8de_pkg::E_NOT_IMPL;
		endcase
		r.ok = (e == c8de_pkg::E_NONE);
		r.err = e;
		r.pc = prog_ctr;
		r.lvl = 5'(sp);
		return r;
	endfunction

	// Sender: holds the word steady until the transaction completes.
	task automatic send_word(input logic [15:0] w, input logic has_exp, input outcome_t exp);
		outcome_t p;
		if ($urandom_range(99) < in_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle);
		end
		in_valid <= 1'b1;
		instruction_word <= w;
		do @(posedge clk); while (!in_ready);
		p = execute_word(w);
		if (has_exp && p != exp) begin
			$error("directed row %h: predictor gives %h, table %h", w, p, exp);
			fails++;
		end
		pending_q.push_back(p);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_top(input logic [11:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		top_addr = v;
	endtask

	always @(posedge clk) begin
		outcome_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got++;
				if (pending_q.size() == 0) begin
					$error("result with nothing expected");
					fails++;
				end else begin
					e = pending_q.pop_front();
					if (instr_type !== e.itype) begin
						$error("instr_type exp %0d got %0d", e.itype, instr_type); fails++;
					end
					if (success !== e.ok) begin
						$error("success exp %0d got %0d", e.ok, success); fails++;
					end
					if (error_code !== e.err) begin
						$error("error_code exp %0d got %0d", e.err, error_code); fails++;
					end
					if (pc_now !== e.pc) begin
						$error("pc_now exp %h got %h", e.pc, pc_now); fails++;
					end
					if (stack_level !== e.lvl) begin
						$error("stack_level exp %0d got %0d", e.lvl, stack_level); fails++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= out_idle);
		end
	end

	typedef struct {
		logic [15:0] w;
		logic has_exp;
		outcome_t exp;
	} row_t;

	function automatic logic [15:0] flow_word();
		logic [15:0] w;
		int k;
		k = $urandom_range(99);
		w = 16'($urandom);
		if (k < 12) w = 16'h00EE;
		else if (k < 20) w[15:12] = 4'h1;
		else if (k < 34) w[15:12] = 4'h2;
		else if (k < 46) w[15:12] = 4'h3;
		else if (k < 58) w[15:12] = 4'h4;
		else if (k < 68) w = {4'h5, w[11:4], 4'h0};
		else if (k < 82) w[15:12] = 4'h6;
		if (k >= 12 && k < 34 && $urandom_range(3) != 0)
			w[11:0] = 12'($urandom_range(32'h100, 32'hFF0));
		if (k >= 34 && k < 58 && $urandom_range(1)) w[7:0] = vreg[w[11:8]];
		return w;
	endfunction

	initial begin
		row_t rows [$];
		int pass_no;
		for (int i = 0; i < DEPTH; i++) ret_stack[i] = '0;
		for (int i = 0; i < 16; i++) vreg[i] = '0;
		top_addr = 12'hFFF;
		prog_ctr = 12'h200;
		sp = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back('{16'h00EE, 1,
			'{c8de_pkg::T_RET, 0, c8de_pkg::E_UNDERFLOW, 12'h200, 0}});
		rows.push_back('{16'h00E0, 1,
			'{c8de_pkg::T_CLS, 0, c8de_pkg::E_NOT_IMPL, 12'h200, 0}});
		rows.push_back('{16'h0000, 1,
			'{c8de_pkg::T_SYS, 0, c8de_pkg::E_NOT_IMPL, 12'h200, 0}});
		rows.push_back('{16'hFFFF, 1,
			'{c8de_pkg::T_INVALID, 0, c8de_pkg::E_NOT_IMPL, 12'h200, 0}});
		rows.push_back('{16'h5121, 1,
			'{c8de_pkg::T_INVALID, 0, c8de_pkg::E_NOT_IMPL, 12'h200, 0}});
		rows.push_back('{16'h8ABF, 1,
			'{c8de_pkg::T_INVALID, 0, c8de_pkg::E_NOT_IMPL, 12'h200, 0}});
		rows.push_back('{16'hE0FF, 1,
			'{c8de_pkg::T_INVALID, 0, c8de_pkg::E_NOT_IMPL, 12'h200, 0}});
		rows.push_back('{16'h1FFE, 1,
			'{c8de_pkg::T_JMP, 1, c8de_pkg::E_NONE, 12'hFFE, 0}});
		rows.push_back('{16'h6A55, 1,
			'{c8de_pkg::T_LD, 0, c8de_pkg::E_INC_FAIL, 12'hFFE, 0}});
		rows.push_back('{16'h2300, 1,
			'{c8de_pkg::T_CALL, 1, c8de_pkg::E_NONE, 12'h300, 1}});
		rows.push_back('{16'h3A55, 0, '0});
		rows.push_back('{16'h4A55, 0, '0});
		rows.push_back('{16'h5AB0, 0, '0});
		rows.push_back('{16'h00EE, 0, '0});
		rows.push_back('{16'h1000, 1,
			'{c8de_pkg::T_JMP, 1, c8de_pkg::E_NONE, 12'h000, 0}});
		for (int i = 0; i < 17; i++) rows.push_back('{16'h2000, 0, '0});
		for (int t = 16'h7000; t <= 16'hD000; t += 16'h1000) rows.push_back('{16'(t), 0, '0});
		foreach (rows[i]) send_word(rows[i].w, rows[i].has_exp, rows[i].exp);
		drain();
		for (int i = 0; i < 16; i++) send_word(16'h00EE, 0, '0);
		send_word(16'hE19E, 0, '0);
		send_word(16'hE1A1, 0, '0);
		for (int n = 0; n < 9; n++)
			send_word({4'hF, 4'h3, n == 0 ? 8'h07 : n == 1 ? 8'h0A : n == 2 ? 8'h15 :
				n == 3 ? 8'h18 : n == 4 ? 8'h1E : n == 5 ? 8'h29 : n == 6 ? 8'h33 :
				n == 7 ? 8'h55 : 8'h65}, 0, '0);
		for (int n = 1; n < 8; n++) send_word({4'h8, 8'h12, 4'(n)}, 0, '0);
		send_word(16'h812E, 0, '0);
		drain();

		for (pass_no = 0; pass_no < 6; pass_no++) begin
			case (pass_no)
				0: write_top(12'h000);
				1: write_top(12'h3FF);
				2: write_top(12'($urandom_range(32'h200, 32'hFFE)));
				default: write_top(12'hFFF);
			endcase
			if (pass_no < 2) begin
				in_idle = 27; out_idle = 75;
			end else if (pass_no < 4) begin
				in_idle = 75; out_idle = 27;
			end else begin
				in_idle = 0; out_idle = 0;
			end
			for (int i = 0; i < 258; i++) begin
				if ($urandom_range(9) < 8) send_word(flow_word(), 0, '0);
				else send_word(16'($urandom), 0, '0);
			end
			drain();
		end

		$display("Ran %0d words, %0d results, over six mem_top settings,", sent, got);
		$display("covering stack overflow/underflow, bad jumps, skips and every opcode class.");
		if (fails == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
